### hw/rtl/ihex_pkg.sv
// Package for the Intel HEX record parser: line phases, status and
// result codes, the result item type and character classification helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

  // Line parsing phase
  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_HIGH = 3'd1,
    PH_LOW  = 3'd2,
    PH_TAIL = 3'd3,
    PH_ERR  = 3'd4
  } phase_e;

  // Record and file status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FORMAT   = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_TYPE     = 3'd3;
  localparam logic [2:0] ST_NODATA   = 3'd4;

  // Result kinds
  localparam logic [1:0] RK_DATA   = 2'd0;
  localparam logic [1:0] RK_RECORD = 2'd1;
  localparam logic [1:0] RK_FILE   = 2'd2;

  // Input kinds
  localparam logic IK_CHAR = 1'b0;
  localparam logic IK_END  = 1'b1;

  // Record types
  localparam logic [7:0] RT_DATA  = 8'h00;
  localparam logic [7:0] RT_EOF   = 8'h01;
  localparam logic [7:0] RT_SSA   = 8'h03;
  localparam logic [7:0] RT_ESA   = 8'h02;
  localparam logic [7:0] RT_ELA   = 8'h04;
  localparam logic [7:0] RT_START = 8'h05;

  // Special characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  // Index of the first data byte within a record
  localparam logic [8:0] POS_DATA = 9'd4;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // One result item
  typedef struct packed {
    logic        last;
    logic [31:0] entry_point;
    logic [7:0]  rec_type;
    logic [2:0]  status;
    logic [7:0]  data_value;
    logic [31:0] byte_address;
    logic [1:0]  result_kind;
  } result_t;

  // Returns {invalid, value}; invalid is set for a non-hex character
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) r = {1'b0, c[3:0]};
    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/intel_hex_record_parser_top.sv
// Intel HEX record parser: line decoder and a small result queue.
// Depends on ihex_pkg.
// Each result is written into the result queue when its input item is accepted.
// One character per cycle while s_axis_tready_o is high; an end-of-input item
// that closes an open line gives two results, which leave through a 4-entry queue.
// s_axis_tready_o is high while the queue has room for two results.
// Reset (rst_ni low, asynchronous) clears all state but the queue storage; the entry register reads 0.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_parser_top
  import ihex_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: default_entry
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  // input items
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] kind
  // result items
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] byte_address, [39:32] data_value, [42:40] status,
  // [50:43] rec_type, [82:51] entry_point, [87:83] zero
  output logic [87:0]      m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o,   // [1:0] result_kind
  output logic             m_axis_tlast_o
);

  // Parser state
  phase_e      phase_q, phase_d;
  logic [8:0]  pos_q, pos_d;
  logic [3:0]  nibble_q, nibble_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] offset_q, offset_d;
  logic [7:0]  rkind_q, rkind_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] payload_q, payload_d;
  logic [31:0] base_q, base_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] dflt_q, dflt_d;
  logic [2:0]  lerr_q, lerr_d;
  logic        seen_data_q, seen_data_d;
  logic        failed_q, failed_d;

  // Result queue
  result_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  logic        s_acc, m_acc, is_end, is_nl;
  logic [7:0]  ch;
  logic [4:0]  hd;
  logic [7:0]  byte_val;
  logic [7:0]  sum_new;
  logic        line_open;
  logic [2:0]  line_st;
  logic        in_payload;
  logic [1:0]  n_res;
  result_t     res0, res1;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (cnt_q <= QCNT_W'(2));
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc           = m_axis_tvalid_o && m_axis_tready_i;
  assign is_end          = (s_axis_tuser_i[0] == IK_END);
  assign ch              = s_axis_tdata_i;
  assign is_nl           = (ch == CH_NEWLINE);
  assign hd              = hex_digit(ch);
  assign byte_val        = {nibble_q, hd[3:0]};
  assign sum_new         = sum_q + byte_val;
  assign line_open       = (phase_q != PH_WAIT);
  assign line_st         = (phase_q == PH_HIGH || phase_q == PH_LOW) ? ST_FORMAT : lerr_q;
  assign in_payload      = (pos_q >= POS_DATA) && (pos_q < ({1'b0, count_q} + POS_DATA));

  // Next state of the line decoder
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    nibble_d    = nibble_q;
    count_d     = count_q;
    offset_d    = offset_q;
    rkind_d     = rkind_q;
    sum_d       = sum_q;
    payload_d   = payload_q;
    base_d      = base_q;
    entry_d     = entry_q;
    dflt_d      = dflt_q;
    lerr_d      = lerr_q;
    seen_data_d = seen_data_q;
    failed_d    = failed_q;
    if (s_acc) begin
      if (is_end) begin
        // close any open line, then start a fresh file
        phase_d     = PH_WAIT;
        base_d      = '0;
        entry_d     = dflt_q;
        seen_data_d = 1'b0;
        failed_d    = 1'b0;
      end else if (is_nl) begin
        if (line_open) begin
          phase_d = PH_WAIT;
          if (line_st != ST_OK) failed_d = 1'b1;
        end
      end else begin
        case (phase_q)
          PH_WAIT: begin
            if (!is_blank(ch)) begin
              pos_d     = '0;
              nibble_d  = '0;
              count_d   = '0;
              offset_d  = '0;
              rkind_d   = '0;
              sum_d     = '0;
              payload_d = '0;
              if (ch == CH_COLON) begin
                phase_d = PH_HIGH;
                lerr_d  = ST_OK;
              end else begin
                phase_d = PH_ERR;
                lerr_d  = ST_FORMAT;
              end
            end
          end
          PH_HIGH, PH_LOW: begin
            if (hd[4]) begin
              phase_d = PH_ERR;
              lerr_d  = ST_FORMAT;
            end else if (phase_q == PH_HIGH) begin
              nibble_d = hd[3:0];
              phase_d  = PH_LOW;
            end else begin
              // a full byte
              phase_d = PH_HIGH;
              sum_d   = sum_new;
              pos_d   = pos_q + 9'd1;
              if (pos_q == 9'd0) count_d = byte_val;
              else if (pos_q == 9'd1) offset_d = {byte_val, offset_q[7:0]};
              else if (pos_q == 9'd2) offset_d = {offset_q[15:8], byte_val};
              else if (pos_q == 9'd3) rkind_d = byte_val;
              else if (in_payload) payload_d = {payload_q[23:0], byte_val};
              else begin
                // checksum byte closes the record
                phase_d = PH_TAIL;
                if (sum_new != 8'd0) lerr_d = ST_CHECKSUM;
                else if (rkind_q == RT_DATA) seen_data_d = 1'b1;
                else if (rkind_q == RT_EOF || rkind_q == RT_SSA) lerr_d = lerr_q;
                else if (rkind_q == RT_ESA && count_q == 8'd2)
                  base_d = {12'd0, payload_q[15:0], 4'd0};
                else if (rkind_q == RT_ELA && count_q == 8'd2)
                  base_d = {payload_q[15:0], 16'd0};
                else if (rkind_q == RT_START && count_q == 8'd4)
                  entry_d = payload_q;
                else lerr_d = ST_TYPE;
              end
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
    // register write also loads the live entry address
    if (cfg_valid_i && cfg_ready_o) begin
      dflt_d  = cfg_data_i;
      entry_d = cfg_data_i;
    end
  end

  // Results caused by the current input item
  always_comb begin
    logic   fail_now;
    logic [2:0] file_st;
    result_t rec_r, file_r, data_r;
    fail_now = failed_q || (line_open && line_st != ST_OK);
    if (fail_now) file_st = ST_FORMAT;
    else if (!seen_data_q) file_st = ST_NODATA;
    else file_st = ST_OK;

    data_r              = '0;
    data_r.result_kind  = RK_DATA;
    data_r.byte_address = base_q + {16'd0, offset_q} + {23'd0, pos_q - POS_DATA};
    data_r.data_value   = byte_val;
    data_r.entry_point  = entry_q;
    data_r.last         = 1'b1;

    rec_r              = '0;
    rec_r.result_kind  = RK_RECORD;
    rec_r.status       = line_st;
    rec_r.rec_type     = rkind_q;
    rec_r.entry_point  = entry_q;

    file_r             = '0;
    file_r.result_kind = RK_FILE;
    file_r.status      = file_st;
    file_r.entry_point = entry_q;
    file_r.last        = 1'b1;

    n_res = 2'd0;
    res0  = data_r;
    res1  = file_r;
    if (is_end) begin
      if (line_open) begin
        n_res = 2'd2;
        res0  = rec_r;
      end else begin
        n_res = 2'd1;
        res0  = file_r;
      end
    end else if (is_nl) begin
      if (line_open) begin
        n_res     = 2'd1;
        res0      = rec_r;
        res0.last = 1'b1;
      end
    end else if (phase_q == PH_LOW && !hd[4] && in_payload && rkind_q == RT_DATA) begin
      n_res = 2'd1;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      pos_q       <= '0;
      nibble_q    <= '0;
      count_q     <= '0;
      offset_q    <= '0;
      rkind_q     <= '0;
      sum_q       <= '0;
      payload_q   <= '0;
      base_q      <= '0;
      entry_q     <= '0;
      dflt_q      <= '0;
      lerr_q      <= ST_OK;
      seen_data_q <= 1'b0;
      failed_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      nibble_q    <= nibble_d;
      count_q     <= count_d;
      offset_q    <= offset_d;
      rkind_q     <= rkind_d;
      sum_q       <= sum_d;
      payload_q   <= payload_d;
      base_q      <= base_d;
      entry_q     <= entry_d;
      dflt_q      <= dflt_d;
      lerr_q      <= lerr_d;
      seen_data_q <= seen_data_d;
      failed_q    <= failed_d;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (s_acc) wr_q <= wr_q + QPTR_W'(n_res);
      if (m_acc) rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_q + (s_acc ? QCNT_W'(n_res) : QCNT_W'(0)) - QCNT_W'(m_acc);
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (s_acc && n_res != 2'd0) q_mem[wr_q] <= res0;
    if (s_acc && n_res == 2'd2) q_mem[wr_q + QPTR_W'(1)] <= res1;
  end

  // Output side
  always_comb begin
    result_t h;
    h               = q_mem[rd_q];
    m_axis_tvalid_o = (cnt_q != '0);
    m_axis_tdata_o  = {5'd0, h.entry_point, h.rec_type, h.status, h.data_value,
                       h.byte_address};
    m_axis_tuser_o  = h.result_kind;
    m_axis_tlast_o  = h.last;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && is_end |=> m_axis_tvalid_o)
    else $error("end of input without result");

  a_file_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == RK_FILE |-> m_axis_tlast_o)
    else $error("file result not marked last");

  a_newline_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !is_end && is_nl |=> phase_q == PH_WAIT)
    else $error("newline left line open");

  a_end_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && is_end |=> !failed_q && !seen_data_q && base_q == 32'd0)
    else $error("file state not cleared at end of input");

endmodule

`default_nettype wire

### sim/intel_hex_record_parser_top_tb.sv
// Self-checking testbench for intel_hex_record_parser_top: feeds Intel HEX text,
// predicts every data byte, record and file result, and compares them item by item.
// Depends on ihex_pkg and the intel_hex_record_parser_top RTL.
`timescale 1ns / 1ps

module intel_hex_record_parser_top_tb;
  import ihex_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_TARGET = 1400;

  // Predicts the parser results and holds the ones still to arrive
  class ihex_scoreboard;
    logic [31:0] dflt_entry;
    phase_e      phase;
    logic [8:0]  pos;
    logic [3:0]  hi_nib;
    logic [7:0]  count;
    logic [15:0] offset;
    logic [7:0]  rec_kind;
    logic [7:0]  csum;
    logic [31:0] payload;
    logic [31:0] base;
    logic [31:0] entry;
    logic [2:0]  line_err;
    logic        seen_data;
    logic        seen_fail;
    result_t     pending_results[$];
    int unsigned n_errors;
    int unsigned n_checked;

    function new();
      dflt_entry = '0;
      phase      = PH_WAIT;
      pos        = '0;
      hi_nib     = '0;
      count      = '0;
      offset     = '0;
      rec_kind   = '0;
      csum       = '0;
      payload    = '0;
      base       = '0;
      entry      = '0;
      line_err   = ST_OK;
      seen_data  = 1'b0;
      seen_fail  = 1'b0;
      n_errors   = 0;
      n_checked  = 0;
    endfunction

    // Register write also reloads the live entry address
    function void load_entry(logic [31:0] v);
      dflt_entry = v;
      entry      = v;
    endfunction

    function logic [4:0] hex_val(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
      return 5'h10;
    endfunction

    function bit is_ws(logic [7:0] c);
      case (c)
        8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function result_t mk_result(logic [1:0] rk, logic [31:0] addr, logic [7:0] dv,
                                logic [2:0] st, logic [7:0] rt);
      result_t r;
      r.result_kind  = rk;
      r.byte_address = addr;
      r.data_value   = dv;
      r.status       = st;
      r.rec_type     = rt;
      r.entry_point  = entry;
      r.last         = 1'b0;
      return r;
    endfunction

    // Newline or end of input: report an open line
    function bit close_line(output result_t r);
      logic [2:0] st;
      if (phase == PH_WAIT) return 1'b0;
      st = (phase == PH_HIGH || phase == PH_LOW) ? ST_FORMAT : line_err;
      if (st != ST_OK) seen_fail = 1'b1;
      r     = mk_result(RK_RECORD, '0, '0, st, rec_kind);
      phase = PH_WAIT;
      return 1'b1;
    endfunction

    // Checksum byte done: apply record effects if every check passes
    function void end_record();
      phase = PH_TAIL;
      if (csum != 8'h00) begin
        line_err = ST_CHECKSUM;
        return;
      end
      case (rec_kind)
        RT_DATA: seen_data = 1'b1;
        RT_EOF, RT_SSA: ;
        RT_ESA: if (count == 8'd2) base = {12'h000, payload[15:0], 4'h0};
                else line_err = ST_TYPE;
        RT_ELA: if (count == 8'd2) base = {payload[15:0], 16'h0000};
                else line_err = ST_TYPE;
        RT_START: if (count == 8'd4) entry = payload;
                  else line_err = ST_TYPE;
        default: line_err = ST_TYPE;
      endcase
    endfunction

    function bit take_byte(logic [7:0] b, output result_t r);
      bit got;
      got  = 1'b0;
      csum = csum + b;
      if (pos == 9'd0) count = b;
      else if (pos == 9'd1) offset = {b, 8'h00};
      else if (pos == 9'd2) offset[7:0] = b;
      else if (pos == 9'd3) rec_kind = b;
      else if (int'(pos) < int'(POS_DATA) + int'(count)) begin
        payload = {payload[23:0], b};
        if (rec_kind == RT_DATA) begin
          r   = mk_result(RK_DATA, base + 32'(offset) + 32'(pos - POS_DATA), b, ST_OK,
                          8'h00);
          got = 1'b1;
        end
      end else begin
        end_record();
      end
      pos = pos + 9'd1;
      return got;
    endfunction

    // One accepted input item: step the line decoder, queue what it yields
    function void absorb_item(logic kind, logic [7:0] c);
      result_t    res[2];
      result_t    r;
      int         n;
      logic [4:0] v;
      logic [2:0] st;
      n = 0;
      if (kind == IK_END) begin
        if (close_line(r)) begin
          res[n] = r;
          n++;
        end
        if (seen_fail) st = ST_FORMAT;
        else if (!seen_data) st = ST_NODATA;
        else st = ST_OK;
        res[n] = mk_result(RK_FILE, '0, '0, st, 8'h00);
        n++;
        base      = '0;
        entry     = dflt_entry;
        seen_data = 1'b0;
        seen_fail = 1'b0;
      end else if (c == CH_NEWLINE) begin
        if (close_line(r)) begin
          res[n] = r;
          n++;
        end
      end else begin
        case (phase)
          PH_WAIT: begin
            if (!is_ws(c)) begin
              pos      = '0;
              hi_nib   = '0;
              count    = '0;
              offset   = '0;
              rec_kind = '0;
              csum     = '0;
              payload  = '0;
              line_err = ST_OK;
              if (c == CH_COLON) begin
                phase = PH_HIGH;
              end else begin
                phase    = PH_ERR;
                line_err = ST_FORMAT;
              end
            end
          end
          PH_HIGH, PH_LOW: begin
            v = hex_val(c);
            if (v[4]) begin
              phase    = PH_ERR;
              line_err = ST_FORMAT;
            end else if (phase == PH_HIGH) begin
              hi_nib = v[3:0];
              phase  = PH_LOW;
            end else begin
              phase = PH_HIGH;
              if (take_byte({hi_nib, v[3:0]}, r)) begin
                res[n] = r;
                n++;
              end
            end
          end
          default: ;  // tail and error phases skip to the newline
        endcase
      end
      for (int i = 0; i < n; i++) begin
        res[i].last = (i == n - 1);
        pending_results.push_back(res[i]);
      end
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      n_errors++;
      $display("result %0d: %s is %h, expected %h", n_checked, field, got, want);
    endtask

    // One accepted result item against the oldest prediction
    task check_result(logic [87:0] data, logic [1:0] user, logic lst);
      result_t e;
      n_checked++;
      if (pending_results.size() == 0) begin
        report("unexpected result, byte_address", data[31:0], '0);
        return;
      end
      e = pending_results.pop_front();
      if (user != e.result_kind)
        report("result_kind", 32'(user), 32'(e.result_kind));
      if (data[31:0] != e.byte_address)   report("byte_address", data[31:0], e.byte_address);
      if (data[39:32] != e.data_value)
        report("data_value", 32'(data[39:32]), 32'(e.data_value));
      if (data[42:40] != e.status)
        report("status", 32'(data[42:40]), 32'(e.status));
      if (data[50:43] != e.rec_type)
        report("rec_type", 32'(data[50:43]), 32'(e.rec_type));
      if (data[82:51] != e.entry_point)   report("entry_point", data[82:51], e.entry_point);
      if (data[87:83] != 5'd0)            report("pad bits", 32'(data[87:83]), '0);
      if (lst != e.last)                  report("tlast", 32'(lst), 32'(e.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic [0:0]  s_user = '0;
  logic        m_ready = 1'b0;
  wire         cfg_ready;
  wire         s_ready;
  wire         m_valid;
  wire [87:0]  m_data;
  wire [1:0]   m_user;
  wire         m_last;

  bit          idle_on = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  ihex_scoreboard sb = new();

  intel_hex_record_parser_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Handshakes sampled with pre-edge values; inputs noted before results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) sb.load_entry(cfg_data);
      if (s_valid && s_ready) sb.absorb_item(s_user[0], s_data);
      if (m_valid && m_ready) sb.check_result(m_data, m_user, m_last);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("intel_hex_record_parser_top_tb: FAIL");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        m_ready <= !(idle_on && $urandom_range(99) < 31);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] c);
    if (idle_on)
      while ($urandom_range(99) < 31) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= c;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Wait until every predicted result is out and the block has gone quiet
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_entry(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(6))
      0: return 8'h09;
      1: return 8'h0B;
      2: return 8'h0C;
      3: return 8'h0D;
      4: return 8'h85;
      5: return 8'hA0;
      default: return 8'h20;
    endcase
  endfunction

  // Characters that are not hex digits; a bad line start may also be a digit
  function automatic logic [7:0] junk_char(input bit at_start);
    logic [7:0] pool [10] = '{8'h47, 8'h67, 8'h78, 8'h2F, 8'h40, 8'h60, 8'h5A,
                              8'h00, 8'hFF, 8'h7F};
    if ($urandom_range(3) == 0) begin
      if (at_start) return ($urandom_range(1) != 0) ? 8'h30 : 8'h46;
      case ($urandom_range(2))
        0: return CH_COLON;
        1: return 8'h20;
        default: return 8'h85;
      endcase
    end
    return pool[$urandom_range(9)];
  endfunction

  // One record line, mostly well formed, sometimes with a flaw
  task automatic send_record(input bit no_newline);
    logic [7:0]  rec_b[$];
    logic [7:0]  text_q[$];
    logic [7:0]  rtype, cnt, sum, chk, b;
    logic [15:0] off;
    int          pick, flaw, hex_at, cut;
    bit          lower;
    pick = $urandom_range(99);
    off  = 16'($urandom);
    if (pick < 55) begin
      rtype = RT_DATA;
      case ($urandom_range(39))
        0: cnt = 8'hFF;
        1, 2, 3, 4: cnt = 8'h00;
        default: cnt = 8'($urandom_range(16, 1));
      endcase
    end else if (pick < 63) begin
      rtype = RT_ELA;
      cnt   = 8'd2;
    end else if (pick < 70) begin
      rtype = RT_ESA;
      cnt   = 8'd2;
    end else if (pick < 77) begin
      rtype = RT_START;
      cnt   = 8'd4;
    end else if (pick < 83) begin
      rtype = RT_EOF;
      cnt   = 8'($urandom_range(2));
    end else if (pick < 88) begin
      rtype = RT_SSA;
      cnt   = 8'd4;
    end else if (pick < 93) begin
      rtype = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255, 6));
      cnt   = 8'($urandom_range(4));
    end else begin
      // address and start records with a random, often wrong, length
      case ($urandom_range(2))
        0: rtype = RT_ESA;
        1: rtype = RT_ELA;
        default: rtype = RT_START;
      endcase
      cnt = 8'($urandom_range(6));
    end
    rec_b = {cnt, off[15:8], off[7:0], rtype};
    for (int i = 0; i < int'(cnt); i++) begin
      b = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
      rec_b.push_back(b);
    end
    sum = '0;
    foreach (rec_b[j]) sum = sum + rec_b[j];
    chk  = 8'h00 - sum;
    flaw = $urandom_range(99);
    if (flaw >= 70 && flaw < 76) chk = chk ^ 8'($urandom_range(255, 1));
    rec_b.push_back(chk);

    lower = 1'($urandom_range(1));
    repeat ($urandom_range(2)) text_q.push_back(blank_char());
    text_q.push_back((flaw >= 93 && flaw < 97) ? junk_char(1'b1) : CH_COLON);
    hex_at = text_q.size();
    foreach (rec_b[j]) begin
      text_q.push_back(hex_char(rec_b[j][7:4], lower));
      text_q.push_back(hex_char(rec_b[j][3:0], lower));
    end
    // bad digit somewhere in the record
    if (flaw >= 76 && flaw < 82)
      text_q[hex_at + $urandom_range(text_q.size() - hex_at - 1)] = junk_char(1'b0);
    // line cut short before the checksum is complete
    if (flaw >= 82 && flaw < 88) begin
      cut = hex_at + $urandom_range(text_q.size() - hex_at - 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
    // text after the checksum
    if (flaw >= 88 && flaw < 93)
      repeat ($urandom_range(4, 1)) begin
        b = 8'($urandom);
        text_q.push_back((b == CH_NEWLINE) ? 8'h20 : b);
      end
    if (!no_newline) text_q.push_back(CH_NEWLINE);
    foreach (text_q[j]) send_item(IK_CHAR, text_q[j]);
  endtask

  // A file: a few lines, then end of input, sometimes with the last line open
  task automatic send_file();
    int         nrec, pick;
    bit         open_end;
    logic [7:0] c;
    nrec     = $urandom_range(6, 1);
    open_end = ($urandom_range(5) == 0);
    for (int k = 0; k < nrec; k++) begin
      pick = $urandom_range(99);
      if (pick < 86) begin
        send_record(open_end && k == nrec - 1);
      end else if (pick < 93) begin
        repeat ($urandom_range(6, 1)) begin
          c = 8'($urandom);
          send_item(IK_CHAR, (c == CH_NEWLINE) ? CH_COLON : c);
        end
        send_item(IK_CHAR, CH_NEWLINE);
      end else begin
        repeat ($urandom_range(3)) send_item(IK_CHAR, blank_char());
        send_item(IK_CHAR, CH_NEWLINE);
      end
    end
    send_item(IK_END, 8'($urandom));
  endtask

  // Main sequence
  initial begin
    logic [31:0] v;
    bit          pressed;
    pressed = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_entry(32'hFFFF_FFFF);

    // Directed: empty line, blank line, bad start, bad digit,
    // open line closed by end of input, file with no records
    send_item(IK_CHAR, CH_NEWLINE);
    send_item(IK_CHAR, 8'h20);
    send_item(IK_CHAR, 8'h09);
    send_item(IK_CHAR, 8'h0B);
    send_item(IK_CHAR, 8'h0C);
    send_item(IK_CHAR, 8'h0D);
    send_item(IK_CHAR, 8'h85);
    send_item(IK_CHAR, 8'hA0);
    send_item(IK_CHAR, CH_NEWLINE);
    send_item(IK_CHAR, 8'h78);
    send_item(IK_CHAR, CH_NEWLINE);
    send_item(IK_CHAR, CH_COLON);
    send_item(IK_CHAR, 8'h47);
    send_item(IK_CHAR, CH_NEWLINE);
    send_item(IK_CHAR, CH_COLON);
    send_item(IK_CHAR, 8'h30);
    send_item(IK_END, 8'hFF);
    send_item(IK_END, 8'h00);
    settle();
    write_entry(32'h0000_0000);

    // Random files: first without idling, then with idling on both sides
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > 450) idle_on = 1'b1;
      if (!pressed && items_sent > 800) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
      end
      send_file();
      if ($urandom_range(3) == 0) begin
        settle();
        case ($urandom_range(3))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
        write_entry(v);
      end
    end
    settle();
    repeat (8) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("intel_hex_record_parser_top_tb: PASS");
    end else begin
      $display("intel_hex_record_parser_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ihex_pkg.sv
hw/rtl/intel_hex_record_parser_top.sv
sim/intel_hex_record_parser_top_tb.sv
